// ----- rtl/ppm_pkg.sv -----
// Package for the polar plot map painter: shared types, codes and reset constants.
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

   // Default plot geometry.
   localparam int AZI_CELLS_DEF   = 1024;
   localparam int RANGE_CELLS_DEF = 256;

   // Field widths fixed by the item format.
   localparam int KIND_W   = 2;
   localparam int AZ_W     = 10;
   localparam int RC_W     = 8;
   localparam int VALUE_W  = 8;
   localparam int HW_W     = 10;
   localparam int NRL_W    = 8;
   localparam int PSM_W    = 10;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_PAINT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Register indexes, taken from address bit 2.
   localparam logic REG_NEAR_RANGE = 1'b0;
   localparam logic REG_PLOT_SIZE  = 1'b1;

   // Register reset values.
   localparam logic [NRL_W-1:0] NRL_RESET = 8'd30;
   localparam logic [PSM_W-1:0] PSM_RESET = 10'd2;

   // Shared arithmetic unit operations.
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic [NRL_W-1:0] near_range_limit;
      logic [PSM_W-1:0] plot_size_marker;
   } csr_regs_type;

   typedef struct packed {
      logic carry;   // carry out on add, borrow on subtract
      logic zero;
   } alu_flags_type;

   typedef struct packed {
      logic write;      // byte write at row and lane
      logic clear_row;  // zero the whole row
      logic read;       // registered byte read at row and lane
   } mem_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/ppm_csr.sv -----
// Configuration register file of the polar plot map painter with its APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module ppm_csr (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [ppm_pkg::CSR_AW-1:0]   paddr,
   input  wire  [ppm_pkg::CSR_DW-1:0]   pwdata,
   output logic [ppm_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   output ppm_pkg::csr_regs_type        regs
);

   ppm_pkg::csr_regs_type regs_ff;
   ppm_pkg::csr_regs_type regs_in;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign regs   = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         case (paddr[2])
            ppm_pkg::REG_NEAR_RANGE: begin
               regs_in.near_range_limit = pwdata[ppm_pkg::NRL_W-1:0];
            end
            ppm_pkg::REG_PLOT_SIZE: begin
               regs_in.plot_size_marker = pwdata[ppm_pkg::PSM_W-1:0];
            end
            default: begin
               regs_in = regs_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         ppm_pkg::REG_NEAR_RANGE: begin
            prdata = ppm_pkg::CSR_DW'(regs_ff.near_range_limit);
         end
         ppm_pkg::REG_PLOT_SIZE: begin
            prdata = ppm_pkg::CSR_DW'(regs_ff.plot_size_marker);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.near_range_limit <= ppm_pkg::NRL_RESET;
         regs_ff.plot_size_marker <= ppm_pkg::PSM_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ppm_plot_mem.sv -----
// Plot memory: one row of byte lanes per azimuth cell, byte writes, row clears, registered reads.
`timescale 1ns / 1ps
`default_nettype none

module ppm_plot_mem #(
   parameter int AZI_CELLS   = ppm_pkg::AZI_CELLS_DEF,
   parameter int RANGE_CELLS = ppm_pkg::RANGE_CELLS_DEF
) (
   input  wire                              clock,
   input  ppm_pkg::mem_ctl_type             ctl,
   input  wire  [$clog2(AZI_CELLS)-1:0]     row,
   input  wire  [$clog2(RANGE_CELLS)-1:0]   lane,
   input  wire  [ppm_pkg::VALUE_W-1:0]      wdata,
   output logic [ppm_pkg::VALUE_W-1:0]      rdata
);

   localparam int VW     = ppm_pkg::VALUE_W;
   localparam int ROW_W  = RANGE_CELLS * VW;
   localparam int LANE_W = $clog2(RANGE_CELLS);

   logic [ROW_W-1:0] mem [AZI_CELLS];
   logic [VW-1:0]    rdata_ff;
   logic [LANE_W+2:0] bit_base;

   assign bit_base = {lane, 3'b000};
   assign rdata    = rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear_row) begin
         mem[row] <= '0;
      end else if (ctl.write) begin
         mem[row][bit_base +: VW] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.read) begin
         rdata_ff <= mem[row][bit_base +: VW];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ppm_alu.sv -----
// Shared add and subtract unit with carry or borrow and zero flags.
`timescale 1ns / 1ps
`default_nettype none

module ppm_alu #(
   parameter int WIDTH = 13
) (
   input  wire                    op,
   input  wire  [WIDTH-1:0]       a,
   input  wire  [WIDTH-1:0]       b,
   output logic [WIDTH-1:0]       result,
   output ppm_pkg::alu_flags_type flags
);

   logic [WIDTH:0] full_sum;

   always_comb begin
      if (op == ppm_pkg::ALU_SUB) begin
         full_sum = {1'b0, a} - {1'b0, b};
      end else begin
         full_sum = {1'b0, a} + {1'b0, b};
      end
      result      = full_sum[WIDTH-1:0];
      flags.carry = full_sum[WIDTH];
      flags.zero  = (full_sum[WIDTH-1:0] == '0);
   end

endmodule

`default_nettype wire

// ----- rtl/ppm_seq.sv -----
// Sequencer of the polar plot map painter: item decode, window setup and cell stepping.
`timescale 1ns / 1ps
`default_nettype none

module ppm_seq #(
   parameter int AZI_CELLS   = ppm_pkg::AZI_CELLS_DEF,
   parameter int RANGE_CELLS = ppm_pkg::RANGE_CELLS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [ppm_pkg::KIND_W-1:0]        req_kind,
   input  wire  [ppm_pkg::AZ_W-1:0]          req_azimuth,
   input  wire  [ppm_pkg::RC_W-1:0]          req_range_cell,
   input  wire  [ppm_pkg::VALUE_W-1:0]       req_paint_value,
   input  wire  [ppm_pkg::HW_W-1:0]          req_half_width,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ppm_pkg::VALUE_W-1:0]       rsp_cell_value,
   output logic                              rsp_rejected,
   input  ppm_pkg::csr_regs_type             regs,
   output ppm_pkg::mem_ctl_type              mem_ctl,
   output logic [$clog2(AZI_CELLS)-1:0]      mem_row,
   output logic [$clog2(RANGE_CELLS)-1:0]    mem_lane,
   output logic [ppm_pkg::VALUE_W-1:0]       mem_wdata,
   input  wire  [ppm_pkg::VALUE_W-1:0]       mem_rdata
);

   localparam int AW    = $clog2(AZI_CELLS);
   localparam int RW    = $clog2(RANGE_CELLS);
   localparam int CW    = AW + 1;
   localparam int DW    = ppm_pkg::HW_W + 1;
   localparam int ALU_W = (AW + 2 > DW + 2) ? AW + 2 : DW + 2;
   localparam int VW    = ppm_pkg::VALUE_W;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_NEAR   = 4'd2;
   localparam logic [3:0] S_MARK   = 4'd3;
   localparam logic [3:0] S_FULL   = 4'd4;
   localparam logic [3:0] S_START  = 4'd5;
   localparam logic [3:0] S_WRAP   = 4'd6;
   localparam logic [3:0] S_PAINT  = 4'd7;
   localparam logic [3:0] S_READ   = 4'd8;
   localparam logic [3:0] S_RDWAIT = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      az_ff, az_in;
   logic [RW-1:0]      rc_ff, rc_in;
   logic [VW-1:0]      value_ff, value_in;
   logic [ppm_pkg::HW_W-1:0] hw_ff, hw_in;
   logic [DW-1:0]      d_ff, d_in;
   logic [RW-1:0]      r_lo_ff, r_lo_in;
   logic [RW-1:0]      r_hi_ff, r_hi_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [AW-1:0]      col_ff, col_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [ALU_W-1:0]   acc_ff, acc_in;
   logic               clear_resp_ff, clear_resp_in;
   logic [VW-1:0]      cell_ff, cell_in;
   logic               rej_ff, rej_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]      rsp_cell_value_ff, rsp_cell_value_in;
   logic               rsp_rejected_ff, rsp_rejected_in;

   logic                  alu_op;
   logic [ALU_W-1:0]      alu_a;
   logic [ALU_W-1:0]      alu_b;
   logic [ALU_W-1:0]      alu_result;
   ppm_pkg::alu_flags_type alu_flags;

   logic accept;
   logic in_bounds;

   ppm_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .flags  (alu_flags)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign accept         = req_valid & ~req_stall;
   assign in_bounds      = (32'(req_azimuth) < AZI_CELLS) && (32'(req_range_cell) < RANGE_CELLS);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_value_ff;
   assign rsp_rejected   = rsp_rejected_ff;
   assign mem_wdata      = value_ff;

   // Operand selection for the shared unit, one use per sequencer step.
   always_comb begin
      alu_op = ppm_pkg::ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         S_NEAR: begin
            alu_op = ppm_pkg::ALU_SUB;
            alu_a  = ALU_W'(rc_ff);
            alu_b  = ALU_W'(regs.near_range_limit);
         end
         S_MARK: begin
            alu_op = ppm_pkg::ALU_SUB;
            alu_a  = ALU_W'(d_ff);
            alu_b  = ALU_W'(regs.plot_size_marker);
         end
         S_FULL: begin
            alu_op = ppm_pkg::ALU_SUB;
            alu_a  = ALU_W'({d_ff, 1'b1});
            alu_b  = ALU_W'(AZI_CELLS);
         end
         S_START: begin
            alu_op = ppm_pkg::ALU_SUB;
            alu_a  = ALU_W'(az_ff);
            alu_b  = ALU_W'(d_ff);
         end
         S_WRAP: begin
            alu_a  = acc_ff;
            alu_b  = ALU_W'(AZI_CELLS);
         end
         S_PAINT, S_CLEAR: begin
            alu_a  = ALU_W'(col_ff);
            alu_b  = ALU_W'(1);
         end
         default: begin
            alu_op = ppm_pkg::ALU_ADD;
         end
      endcase
   end

   // Memory control.
   always_comb begin
      mem_ctl.write     = 1'b0;
      mem_ctl.clear_row = 1'b0;
      mem_ctl.read      = 1'b0;
      mem_row           = col_ff;
      mem_lane          = row_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_ctl.clear_row = 1'b1;
         end
         S_PAINT: begin
            mem_ctl.write = 1'b1;
         end
         S_READ: begin
            mem_ctl.read = 1'b1;
            mem_row      = az_ff;
            mem_lane     = rc_ff;
         end
         default: begin
            mem_ctl.write = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      az_in             = az_ff;
      rc_in             = rc_ff;
      value_in          = value_ff;
      hw_in             = hw_ff;
      d_in              = d_ff;
      r_lo_in           = r_lo_ff;
      r_hi_in           = r_hi_ff;
      row_in            = row_ff;
      col_in            = col_ff;
      cnt_in            = cnt_ff;
      acc_in            = acc_ff;
      clear_resp_in     = clear_resp_ff;
      cell_in           = cell_ff;
      rej_in            = rej_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      rsp_cell_value_in = rsp_cell_value_ff;
      rsp_rejected_in   = rsp_rejected_ff;

      case (state_ff)
         S_CLEAR: begin
            col_in = alu_result[AW-1:0];
            if (col_ff == AW'(AZI_CELLS - 1)) begin
               state_in = clear_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               az_in    = AW'(req_azimuth);
               rc_in    = RW'(req_range_cell);
               value_in = req_paint_value;
               hw_in    = req_half_width;
               cell_in  = '0;
               rej_in   = 1'b0;
               case (req_kind)
                  ppm_pkg::KIND_PAINT: begin
                     if (in_bounds) begin
                        state_in = S_NEAR;
                     end else begin
                        rej_in   = 1'b1;
                        state_in = S_RESP;
                     end
                  end
                  ppm_pkg::KIND_CLEAR: begin
                     col_in        = '0;
                     clear_resp_in = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  ppm_pkg::KIND_READ: begin
                     state_in = in_bounds ? S_READ : S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_NEAR: begin
            // Borrow means the range cell lies below the near-range limit.
            d_in     = alu_flags.carry ? {hw_ff, 1'b0} : {1'b0, hw_ff};
            state_in = S_MARK;
         end
         S_MARK: begin
            if (alu_flags.zero) begin
               r_lo_in = (rc_ff == '0) ? rc_ff : rc_ff - 1'b1;
               r_hi_in = (rc_ff == RW'(RANGE_CELLS - 1)) ? rc_ff : rc_ff + 1'b1;
            end else begin
               r_lo_in = rc_ff;
               r_hi_in = rc_ff;
            end
            state_in = S_FULL;
         end
         S_FULL: begin
            row_in = r_lo_ff;
            if (!alu_flags.carry) begin
               // The window reaches all the way around the ring.
               col_in   = '0;
               cnt_in   = CW'(AZI_CELLS);
               state_in = S_PAINT;
            end else begin
               cnt_in   = CW'({d_ff, 1'b1});
               state_in = S_START;
            end
         end
         S_START: begin
            acc_in = alu_result;
            col_in = alu_result[AW-1:0];
            state_in = alu_flags.carry ? S_WRAP : S_PAINT;
         end
         S_WRAP: begin
            col_in   = alu_result[AW-1:0];
            state_in = S_PAINT;
         end
         S_PAINT: begin
            if (row_ff == r_hi_ff) begin
               row_in = r_lo_ff;
               if (cnt_ff == CW'(1)) begin
                  state_in = S_RESP;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  col_in = (alu_result == ALU_W'(AZI_CELLS)) ? '0 : alu_result[AW-1:0];
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_RDWAIT;
         end
         S_RDWAIT: begin
            cell_in  = mem_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_cell_value_in = cell_ff;
               rsp_rejected_in   = rej_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         col_ff        <= '0;
         clear_resp_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         clear_resp_ff <= (state_in == S_CLEAR) ? clear_resp_in : 1'b0;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      az_ff             <= az_in;
      rc_ff             <= rc_in;
      value_ff          <= value_in;
      hw_ff             <= hw_in;
      d_ff              <= d_in;
      r_lo_ff           <= r_lo_in;
      r_hi_ff           <= r_hi_in;
      row_ff            <= row_in;
      cnt_ff            <= cnt_in;
      acc_ff            <= acc_in;
      cell_ff           <= cell_in;
      rej_ff            <= rej_in;
      rsp_cell_value_ff <= rsp_cell_value_in;
      rsp_rejected_ff   <= rsp_rejected_in;
   end

endmodule

`default_nettype wire

// ----- rtl/polar_plot_map_painter_unit.sv -----
// Top level of the polar plot map painter: register file, sequencer and plot memory.
// Paint windows span one to three rows; a window may wrap below azimuth zero or cover the whole ring.
// Throughput: one transaction at a time; the next is taken the cycle after the result loads.
// The memory port writes one cell or clears one row per cycle.
// Reset: synchronous; a clearing pass over every row follows, with requests stalled.
`timescale 1ns / 1ps
`default_nettype none

module polar_plot_map_painter_unit #(
   parameter int AZI_CELLS   = ppm_pkg::AZI_CELLS_DEF,
   parameter int RANGE_CELLS = ppm_pkg::RANGE_CELLS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   // Request channel.
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [ppm_pkg::KIND_W-1:0]    req_kind,
   input  wire  [ppm_pkg::AZ_W-1:0]      req_azimuth,
   input  wire  [ppm_pkg::RC_W-1:0]      req_range_cell,
   input  wire  [ppm_pkg::VALUE_W-1:0]   req_paint_value,
   input  wire  [ppm_pkg::HW_W-1:0]      req_half_width,
   // Response channel.
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [ppm_pkg::VALUE_W-1:0]   rsp_cell_value,
   output logic                          rsp_rejected,
   // Configuration port.
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire  [ppm_pkg::CSR_AW-1:0]    paddr,
   input  wire  [ppm_pkg::CSR_DW-1:0]    pwdata,
   output logic [ppm_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int AW = $clog2(AZI_CELLS);
   localparam int RW = $clog2(RANGE_CELLS);

   // The plot memory holds one row per azimuth cell, each row a set of byte lanes, one
   // lane per range cell. A paint transaction writes one lane per cycle; a clear, and the
   // pass that follows reset, zero one whole row per cycle.

   ppm_pkg::csr_regs_type regs;
   ppm_pkg::mem_ctl_type  mem_ctl;
   logic [AW-1:0]         mem_row;
   logic [RW-1:0]         mem_lane;
   logic [ppm_pkg::VALUE_W-1:0] mem_wdata;
   logic [ppm_pkg::VALUE_W-1:0] mem_rdata;

   // Configuration registers are written at the access phase of a write. They may be
   // written at any time, including during the clearing pass after reset.
   ppm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   // The sequencer steps each transaction through its setup and painting steps, using one
   // shared adder for the near-range test, the plot size compare, the ring coverage test,
   // the window start with its wrap, and the column and row-clear increments.
   ppm_seq #(
      .AZI_CELLS   (AZI_CELLS),
      .RANGE_CELLS (RANGE_CELLS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_azimuth     (req_azimuth),
      .req_range_cell  (req_range_cell),
      .req_paint_value (req_paint_value),
      .req_half_width  (req_half_width),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_rejected    (rsp_rejected),
      .regs            (regs),
      .mem_ctl         (mem_ctl),
      .mem_row         (mem_row),
      .mem_lane        (mem_lane),
      .mem_wdata       (mem_wdata),
      .mem_rdata       (mem_rdata)
   );

   // Plot memory with a registered read port.
   ppm_plot_mem #(
      .AZI_CELLS   (AZI_CELLS),
      .RANGE_CELLS (RANGE_CELLS)
   ) u_plot_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .row   (mem_row),
      .lane  (mem_lane),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

// ----- sim/ppm_result_checker.sv -----
// Response checker for the polar plot map painter: mirrors the plot memory and checks each response.
`timescale 1ns / 1ps

module ppm_result_checker #(
   parameter int AZI_CELLS   = ppm_pkg::AZI_CELLS_DEF,
   parameter int RANGE_CELLS = ppm_pkg::RANGE_CELLS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_stall,
   input  wire  [ppm_pkg::KIND_W-1:0]    req_kind,
   input  wire  [ppm_pkg::AZ_W-1:0]      req_azimuth,
   input  wire  [ppm_pkg::RC_W-1:0]      req_range_cell,
   input  wire  [ppm_pkg::VALUE_W-1:0]   req_paint_value,
   input  wire  [ppm_pkg::HW_W-1:0]      req_half_width,
   input  wire                           rsp_valid,
   input  wire                           rsp_stall,
   input  wire  [ppm_pkg::VALUE_W-1:0]   rsp_cell_value,
   input  wire                           rsp_rejected,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire  [ppm_pkg::CSR_AW-1:0]    paddr,
   input  wire  [ppm_pkg::CSR_DW-1:0]    pwdata,
   input  wire  [ppm_pkg::CSR_DW-1:0]    prdata,
   input  wire                           pready,
   output int                            error_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [ppm_pkg::VALUE_W-1:0] cell_value;
      logic                        rejected;
   } plot_response_type;

   // A bit array starts at zero, which matches the memory after its clearing pass.
   bit   [ppm_pkg::VALUE_W-1:0] plot_image [AZI_CELLS*RANGE_CELLS];
   logic [ppm_pkg::NRL_W-1:0]   near_limit = ppm_pkg::NRL_RESET;
   logic [ppm_pkg::PSM_W-1:0]   size_marker = ppm_pkg::PSM_RESET;
   plot_response_type           awaited_responses [$];
   int                          mismatches = 0;

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: %s", $time, msg);
   endtask

   task automatic paint_window(input int az, input int rc,
                               input logic [ppm_pkg::VALUE_W-1:0] value,
                               input int hw, output logic rejected);
      int d;
      int r_lo;
      int r_hi;
      int first;
      int span;
      int k;
      int r;
      d = (rc < near_limit) ? 2 * hw : hw;
      rejected = 1'b0;
      if (az >= AZI_CELLS || rc >= RANGE_CELLS) begin
         rejected = 1'b1;
      end else begin
         r_lo = rc;
         r_hi = rc;
         if (d == size_marker) begin
            r_lo = (rc > 0) ? rc - 1 : 0;
            r_hi = (rc + 1 < RANGE_CELLS) ? rc + 1 : RANGE_CELLS - 1;
         end
         if (2 * d + 1 >= AZI_CELLS) begin
            first = 0;
            span = AZI_CELLS;
         end else begin
            first = (az + AZI_CELLS - d) % AZI_CELLS;
            span = 2 * d + 1;
         end
         for (k = 0; k < span; k++)
            for (r = r_lo; r <= r_hi; r++)
               plot_image[((first + k) % AZI_CELLS) * RANGE_CELLS + r] = value;
      end
   endtask

   task automatic predict_response(input logic [ppm_pkg::KIND_W-1:0] kind, input int az,
                                   input int rc, input logic [ppm_pkg::VALUE_W-1:0] value,
                                   input int hw, output plot_response_type resp);
      logic rej;
      resp = '0;
      case (kind)
         ppm_pkg::KIND_PAINT: begin
            paint_window(az, rc, value, hw, rej);
            resp.rejected = rej;
         end
         ppm_pkg::KIND_CLEAR: begin
            foreach (plot_image[i])
               plot_image[i] = '0;
         end
         ppm_pkg::KIND_READ: begin
            if (az < AZI_CELLS && rc < RANGE_CELLS)
               resp.cell_value = plot_image[az * RANGE_CELLS + rc];
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      plot_response_type want;
      plot_response_type got;
      if (reset) begin
         near_limit = ppm_pkg::NRL_RESET;
         size_marker = ppm_pkg::PSM_RESET;
         awaited_responses.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == ppm_pkg::REG_NEAR_RANGE)
                  near_limit = pwdata[ppm_pkg::NRL_W-1:0];
               else
                  size_marker = pwdata[ppm_pkg::PSM_W-1:0];
            end else if (paddr[2] == ppm_pkg::REG_NEAR_RANGE) begin
               if (prdata[ppm_pkg::NRL_W-1:0] !== near_limit)
                  note_failure($sformatf("near range readback: expected %0d, got %0d",
                                         near_limit, prdata[ppm_pkg::NRL_W-1:0]));
            end else if (prdata[ppm_pkg::PSM_W-1:0] !== size_marker) begin
               note_failure($sformatf("plot size readback: expected %0d, got %0d",
                                      size_marker, prdata[ppm_pkg::PSM_W-1:0]));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.cell_value = rsp_cell_value;
            got.rejected = rsp_rejected;
            if (awaited_responses.size() == 0) begin
               note_failure($sformatf("unexpected response: cell_value %h rejected %b",
                                      got.cell_value, got.rejected));
            end else begin
               want = awaited_responses.pop_front();
               if (got.cell_value !== want.cell_value || got.rejected !== want.rejected)
                  note_failure($sformatf(
                     "response mismatch: expected cell_value %h rejected %b, got %h %b",
                     want.cell_value, want.rejected, got.cell_value, got.rejected));
            end
         end
         if (req_valid && !req_stall) begin
            predict_response(req_kind, int'(req_azimuth), int'(req_range_cell),
                             req_paint_value, int'(req_half_width), want);
            awaited_responses.push_back(want);
         end
      end
      error_count <= mismatches;
      pending_count <= awaited_responses.size();
   end

endmodule

// ----- sim/polar_plot_map_painter_unit_test.sv -----
// Testbench top for the polar plot map painter: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module polar_plot_map_painter_unit_test;

   localparam int AZI = ppm_pkg::AZI_CELLS_DEF;
   localparam int RNG = ppm_pkg::RANGE_CELLS_DEF;

   // The fourth kind code is not used by the block; it must still answer with zeros.
   localparam logic [ppm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 90;
   localparam int PHASE_COUNT     = 5;
   localparam int TIMEOUT_CYCLES  = 10_000_000;
   // A whole-ring paint over three rows is the longest transaction the block performs.
   localparam int DRAIN_CYCLES    = 3 * AZI + 16;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic [ppm_pkg::KIND_W-1:0]    req_kind = ppm_pkg::KIND_PAINT;
   logic [ppm_pkg::AZ_W-1:0]      req_azimuth = '0;
   logic [ppm_pkg::RC_W-1:0]      req_range_cell = '0;
   logic [ppm_pkg::VALUE_W-1:0]   req_paint_value = '0;
   logic [ppm_pkg::HW_W-1:0]      req_half_width = '0;
   logic                          rsp_stall = 1'b0;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [ppm_pkg::CSR_AW-1:0]    paddr = '0;
   logic [ppm_pkg::CSR_DW-1:0]    pwdata = '0;

   wire                           req_stall;
   wire                           rsp_valid;
   wire  [ppm_pkg::VALUE_W-1:0]   rsp_cell_value;
   wire                           rsp_rejected;
   wire  [ppm_pkg::CSR_DW-1:0]    prdata;
   wire                           pready;

   int error_count;
   int pending_count;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Register values currently programmed, used only to steer the random stimulus
   // toward the near-range boundary and the plot size marker.
   logic [ppm_pkg::NRL_W-1:0] cur_near = ppm_pkg::NRL_RESET;
   logic [ppm_pkg::PSM_W-1:0] cur_marker = ppm_pkg::PSM_RESET;

   // Centers and effective half-widths of recent paints, so that reads land on painted cells.
   int recent_az [$];
   int recent_rc [$];
   int recent_d [$];

   polar_plot_map_painter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_azimuth     (req_azimuth),
      .req_range_cell  (req_range_cell),
      .req_paint_value (req_paint_value),
      .req_half_width  (req_half_width),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_rejected    (rsp_rejected),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   ppm_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_azimuth     (req_azimuth),
      .req_range_cell  (req_range_cell),
      .req_paint_value (req_paint_value),
      .req_half_width  (req_half_width),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_rejected    (rsp_rejected),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver decides afresh at every edge whether to stall the next cycle.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // Offers one request transaction and returns at the edge where it is accepted.
   // Valid stays high into the next call unless that call chooses to idle first, so
   // back-to-back transactions never lower and raise valid in the same time step.
   task automatic send_item(input logic [ppm_pkg::KIND_W-1:0] kind,
                            input logic [ppm_pkg::AZ_W-1:0] az,
                            input logic [ppm_pkg::RC_W-1:0] rc,
                            input logic [ppm_pkg::VALUE_W-1:0] value,
                            input logic [ppm_pkg::HW_W-1:0] hw);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_azimuth <= az;
      req_range_cell <= rc;
      req_paint_value <= value;
      req_half_width <= hw;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drops valid and waits until every predicted response has come back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // One bus access: a setup phase, then an access phase that completes when pready is high.
   // The bus is left selected so that another access may follow directly.
   task automatic csr_access(input logic write, input logic reg_sel,
                             input logic [ppm_pkg::CSR_DW-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {reg_sel, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
   endtask

   // Writes both registers and reads them back; the checker compares the read data.
   task automatic set_registers(input logic [ppm_pkg::NRL_W-1:0] near,
                                input logic [ppm_pkg::PSM_W-1:0] marker);
      csr_access(1'b1, ppm_pkg::REG_NEAR_RANGE, ppm_pkg::CSR_DW'(near));
      csr_access(1'b1, ppm_pkg::REG_PLOT_SIZE, ppm_pkg::CSR_DW'(marker));
      csr_access(1'b0, ppm_pkg::REG_NEAR_RANGE, '0);
      csr_access(1'b0, ppm_pkg::REG_PLOT_SIZE, '0);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cur_near = near;
      cur_marker = marker;
   endtask

   // Builds one random transaction. Paints and reads dominate; reads mostly revisit cells
   // around recent paints, and paints are steered toward the near-range boundary and the
   // half-width that widens the window in range. Clears are rare since each sweeps the ring.
   task automatic send_random_item();
      int                         pick;
      int                         az;
      int                         rc;
      int                         hw;
      int                         idx;
      int                         span;
      int                         offset;
      logic [ppm_pkg::KIND_W-1:0] kind;
      pick = $urandom_range(99);
      az = $urandom_range(AZI - 1);
      rc = $urandom_range(RNG - 1);
      hw = $urandom_range((1 << ppm_pkg::HW_W) - 1);
      if (pick < 1) begin
         kind = ppm_pkg::KIND_CLEAR;
         recent_az.delete();
         recent_rc.delete();
         recent_d.delete();
      end else if (pick < 4) begin
         kind = KIND_UNUSED;
      end else if (pick < 50) begin
         kind = ppm_pkg::KIND_READ;
         if (recent_az.size() != 0 && $urandom_range(99) < 70) begin
            idx = $urandom_range(recent_az.size() - 1);
            span = (recent_d[idx] < 8) ? recent_d[idx] + 1 : 8;
            offset = $urandom_range(2 * span);
            az = (recent_az[idx] + AZI + offset - span) % AZI;
            offset = $urandom_range(2);
            rc = recent_rc[idx] + offset - 1;
         end
      end else begin
         kind = ppm_pkg::KIND_PAINT;
         if ($urandom_range(1) == 1) begin
            offset = $urandom_range(3);
            rc = int'(cur_near) + offset - 2;
         end
         if (rc < 0)
            rc = 0;
         if (rc > RNG - 1)
            rc = RNG - 1;
         pick = $urandom_range(99);
         // Most windows are a few cells wide; some hit the marker, a few are arbitrary.
         if (pick < 75)
            hw = $urandom_range(6);
         else if (pick < 92)
            hw = (rc < cur_near) ? int'(cur_marker) / 2 : int'(cur_marker);
         recent_az.push_back(az);
         recent_rc.push_back(rc);
         recent_d.push_back((rc < cur_near) ? 2 * hw : hw);
         if (recent_az.size() > 8) begin
            void'(recent_az.pop_front());
            void'(recent_rc.pop_front());
            void'(recent_d.pop_front());
         end
      end
      if (rc < 0)
         rc = 0;
      if (rc > RNG - 1)
         rc = RNG - 1;
      send_item(kind, az[ppm_pkg::AZ_W-1:0], rc[ppm_pkg::RC_W-1:0],
                ppm_pkg::VALUE_W'($urandom_range(255)), hw[ppm_pkg::HW_W-1:0]);
   endtask

   // Each phase programs a new pair of register values, extremes included, and applies a
   // mix of sender idling and receiver stalling.
   task automatic start_phase(input int phase);
      case (phase)
         0: begin
            set_registers(8'd0, 10'd0);
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            set_registers(8'd255, 10'd512);
            send_idle_pct = 66;
            recv_stall_pct = 0;
         end
         2: begin
            set_registers(8'd128, 10'd4);
            send_idle_pct = 0;
            recv_stall_pct = 66;
         end
         3: begin
            set_registers(8'd1, 10'd1023);
            send_idle_pct = 10;
            recv_stall_pct = 10;
         end
         default: begin
            set_registers(ppm_pkg::NRL_RESET, ppm_pkg::PSM_RESET);
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   initial begin : stimulus
      int phase;
      int n;

      // Once reset is released, the block runs its own clearing pass with requests stalled,
      // which the first request simply waits out through the handshake.
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_registers(ppm_pkg::NRL_RESET, ppm_pkg::PSM_RESET);

      // Directed transactions under the reset register values (near limit 30, marker 2).
      send_item(ppm_pkg::KIND_READ, 10'd0, 8'd0, 8'h00, 10'd0);
      // Zero half-width at the ring origin paints a single column.
      send_item(ppm_pkg::KIND_PAINT, 10'd0, 8'd0, 8'hFF, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd0, 8'd0, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd1023, 8'd0, 8'h00, 10'd0);
      // Window wrapping past the top of the ring at the last range cell; the half-width
      // equals the marker, so the range window is clamped at the upper edge.
      send_item(ppm_pkg::KIND_PAINT, 10'd1023, 8'd255, 8'hA5, 10'd2);
      send_item(ppm_pkg::KIND_READ, 10'd1, 8'd255, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd1, 8'd254, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd2, 8'd255, 8'h00, 10'd0);
      // Near range: the half-width is doubled onto the marker and three rows are painted.
      send_item(ppm_pkg::KIND_PAINT, 10'd512, 8'd10, 8'h5A, 10'd1);
      send_item(ppm_pkg::KIND_READ, 10'd510, 8'd9, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd515, 8'd10, 8'h00, 10'd0);
      // Largest half-width: the window covers the whole ring.
      send_item(ppm_pkg::KIND_PAINT, 10'd100, 8'd200, 8'h3C, 10'd1023);
      send_item(ppm_pkg::KIND_READ, 10'd700, 8'd200, 8'h00, 10'd0);
      // Near range doubles this half-width; the window covers the whole ring.
      send_item(ppm_pkg::KIND_PAINT, 10'd5, 8'd3, 8'hC3, 10'd512);
      send_item(ppm_pkg::KIND_READ, 10'd900, 8'd3, 8'h00, 10'd0);
      // One column short of the whole ring: only the column opposite the center survives.
      send_item(ppm_pkg::KIND_PAINT, 10'd0, 8'd200, 8'h00, 10'd511);
      send_item(ppm_pkg::KIND_READ, 10'd512, 8'd200, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd511, 8'd200, 8'h00, 10'd0);
      // The unused kind with every field at its maximum must change nothing.
      send_item(KIND_UNUSED, 10'd1023, 8'd255, 8'hFF, 10'd1023);
      send_item(ppm_pkg::KIND_READ, 10'd900, 8'd3, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_CLEAR, 10'd0, 8'd0, 8'h00, 10'd0);
      send_item(ppm_pkg::KIND_READ, 10'd900, 8'd3, 8'h00, 10'd0);
      // Just inside the near-range limit, wrapping past the top of the ring.
      send_item(ppm_pkg::KIND_PAINT, 10'd1023, 8'd29, 8'h81, 10'd1);
      send_item(ppm_pkg::KIND_READ, 10'd1, 8'd28, 8'h00, 10'd0);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // Registers only change once the block has answered everything.
         wait_for_responses();
         start_phase(phase);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Midway through one phase the sender holds off until the pipeline drains.
            if (phase == 2 && n == ITEMS_PER_PHASE / 2)
               wait_for_responses();
            send_random_item();
         end
      end

      // Let every outstanding response arrive, then watch a while for any stray one.
      wait_for_responses();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ppm_pkg.sv
rtl/ppm_csr.sv
rtl/ppm_plot_mem.sv
rtl/ppm_alu.sv
rtl/ppm_seq.sv
rtl/polar_plot_map_painter_unit.sv
sim/ppm_result_checker.sv
sim/polar_plot_map_painter_unit_test.sv
